### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tlpt_pkg.sv
// ----------------------------------------------------------------------------
// tlpt_pkg
// Types and constants of the two-level page table engine.
// ----------------------------------------------------------------------------
package tlpt_pkg;

    localparam int DIR_ENTRIES = 1024;
    localparam int TBL_ENTRIES = 1024;
    localparam int IDX_W       = 10;
    localparam int OFS_W       = 12;
    localparam int FLAG_W      = 6;
    localparam int FRAME_W     = 20;
    localparam int ENT_W       = FRAME_W + FLAG_W;
    localparam int FLAG_PRESENT_BIT = 0;
    localparam int FLAG_WRITE_BIT   = 1;

    typedef enum logic [2:0] {
        OP_MAP   = 3'd0,
        OP_UNMAP = 3'd1,
        OP_SETF  = 3'd2,
        OP_XLATE = 3'd3,
        OP_GETF  = 3'd4,
        OP_CHECK = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_UNMAPPED = 2'd1,
        ST_NO_SLOT  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DIR,
        S_ENT
    } fsm_t;

    typedef struct packed {
        logic [2:0]        operation;
        logic [31:0]       vaddr;
        logic [31:0]       paddr;
        logic [FLAG_W-1:0] flags;
        logic              wr_access;
        logic              is_user;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [31:0]       phys_out;
        logic [FLAG_W-1:0] flags_out;
        logic              accessible;
    } rsp_t;

endpackage

### rtl/tlpt_mem.sv
// ----------------------------------------------------------------------------
// tlpt_mem
// Simple dual-port synchronous RAM with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module tlpt_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/tlpt_ctrl.sv
// ----------------------------------------------------------------------------
// tlpt_ctrl
// Sequencer of the page table engine: clears the memories after reset, walks
// the directory and the table entry of each item, writes back and holds the
// result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlpt_ctrl #(
    parameter int TABLE_SLOTS = 16,
    parameter int SLOT_W      = 4,
    parameter int ENT_AW      = 14,
    parameter int CNT_W       = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  tlpt_pkg::req_t          req,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output tlpt_pkg::rsp_t          rsp,
    output logic                    dir_we,
    output logic [tlpt_pkg::IDX_W-1:0] dir_waddr,
    output logic [SLOT_W:0]         dir_wdata,
    output logic                    dir_re,
    output logic [tlpt_pkg::IDX_W-1:0] dir_raddr,
    input  logic [SLOT_W:0]         dir_rdata,
    output logic                    ent_we,
    output logic [ENT_AW-1:0]       ent_waddr,
    output logic [tlpt_pkg::ENT_W-1:0] ent_wdata,
    output logic                    ent_re,
    output logic [ENT_AW-1:0]       ent_raddr,
    input  logic [tlpt_pkg::ENT_W-1:0] ent_rdata
);

    import tlpt_pkg::*;

    localparam logic [ENT_AW-1:0] CLR_LAST = ENT_AW'(TABLE_SLOTS * TBL_ENTRIES - 1);
    localparam logic [CNT_W-1:0]  SLOT_CNT = CNT_W'(TABLE_SLOTS);

    fsm_t               state_reg, state_next;
    logic [ENT_AW-1:0]  clr_reg, clr_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    req_t               req_reg, req_next;
    logic               hit_reg, hit_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               out_valid_reg, out_valid_next;
    rsp_t               out_data_reg, out_data_next;

    logic [IDX_W-1:0]   dir_idx;
    logic [IDX_W-1:0]   tbl_idx;
    logic               mapped;
    logic               fire;
    rsp_t               result;

    assign dir_idx = req_reg.vaddr[31:22];
    assign tbl_idx = req_reg.vaddr[21:12];
    assign mapped  = hit_reg && ent_rdata[FLAG_PRESENT_BIT];
    assign fire    = !out_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        hit_reg      <= hit_next;
        slot_reg     <= slot_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        used_next      = used_reg;
        req_next       = req_reg;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_data_next  = out_data_reg;
        req_ready      = 1'b0;
        dir_we         = 1'b0;
        dir_waddr      = dir_idx;
        dir_wdata      = '0;
        dir_re         = 1'b0;
        dir_raddr      = req.vaddr[31:22];
        ent_we         = 1'b0;
        ent_waddr      = {slot_reg, tbl_idx};
        ent_wdata      = '0;
        ent_re         = 1'b0;
        ent_raddr      = {dir_rdata[SLOT_W-1:0], tbl_idx};
        result         = '0;

        case (op_t'(req_reg.operation))
            OP_MAP:
            begin
                if (!hit_reg && used_reg >= SLOT_CNT)
                begin
                    result.status = ST_NO_SLOT;
                end
            end
            OP_UNMAP, OP_SETF, OP_GETF:
            begin
                if (!mapped)
                begin
                    result.status = ST_UNMAPPED;
                end
                else if (op_t'(req_reg.operation) == OP_GETF)
                begin
                    result.flags_out = ent_rdata[FLAG_W-1:0];
                end
            end
            OP_XLATE:
            begin
                if (!mapped)
                begin
                    result.status = ST_UNMAPPED;
                end
                else
                begin
                    result.phys_out = {ent_rdata[ENT_W-1:FLAG_W], req_reg.vaddr[OFS_W-1:0]};
                end
            end
            OP_CHECK:
            begin
                if (!mapped)
                begin
                    result.status = ST_UNMAPPED;
                end
                else
                begin
                    result.accessible = !req_reg.is_user
                        && (!req_reg.wr_access || ent_rdata[FLAG_WRITE_BIT]);
                end
            end
            default:
            begin
                result = '0;
            end
        endcase

        case (state_reg)
            S_CLEAR:
            begin
                ent_we    = 1'b1;
                ent_waddr = clr_reg;
                ent_wdata = '0;
                dir_we    = (clr_reg[ENT_AW-1:IDX_W] == '0);
                dir_waddr = clr_reg[IDX_W-1:0];
                dir_wdata = '0;
                clr_next  = clr_reg + ENT_AW'(1);
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    req_next   = req;
                    dir_re     = 1'b1;
                    state_next = S_DIR;
                end
            end
            S_DIR:
            begin
                hit_next   = dir_rdata[SLOT_W];
                slot_next  = dir_rdata[SLOT_W-1:0];
                ent_re     = 1'b1;
                state_next = S_ENT;
            end
            S_ENT:
            begin
                if (fire)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = result;
                    state_next     = S_IDLE;
                    case (op_t'(req_reg.operation))
                        OP_MAP:
                        begin
                            ent_wdata = {req_reg.paddr[31:12], req_reg.flags};
                            if (hit_reg)
                            begin
                                ent_we = 1'b1;
                            end
                            else if (used_reg < SLOT_CNT)
                            begin
                                dir_we    = 1'b1;
                                dir_wdata = {1'b1, used_reg[SLOT_W-1:0]};
                                ent_we    = 1'b1;
                                ent_waddr = {used_reg[SLOT_W-1:0], tbl_idx};
                                used_next = used_reg + CNT_W'(1);
                            end
                        end
                        OP_UNMAP:
                        begin
                            ent_we    = mapped;
                            ent_wdata = {ent_rdata[ENT_W-1:1], 1'b0};
                        end
                        OP_SETF:
                        begin
                            ent_we    = mapped;
                            ent_wdata = {ent_rdata[ENT_W-1:FLAG_W], req_reg.flags};
                        end
                        default:
                        begin
                            ent_we = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    `ASSERT_ALWAYS(a_slots_bounded, used_reg <= SLOT_CNT, "slot count exceeds the pool")
    `ASSERT_SAME(a_no_result_in_clear, state_reg == S_CLEAR, !out_valid_reg,
                 "result valid during the clearing pass")
    `ASSERT_NEXT(a_accept_walks, req_valid && req_ready, state_reg == S_DIR,
                 "accepted item did not start the directory read")
    `ASSERT_NEXT(a_alloc_counts, state_reg == S_ENT && dir_we,
                 used_reg == $past(used_reg) + CNT_W'(1),
                 "directory allocation did not advance the slot count")
    `ASSERT_NEXT(a_stall_holds, state_reg == S_ENT && out_valid_reg && !rsp_ready,
                 state_reg == S_ENT && $stable(used_reg),
                 "item completed while the result register was blocked")

endmodule

### rtl/two_level_page_table_engine_core.sv
// ----------------------------------------------------------------------------
// two_level_page_table_engine_core
// Two-level page table held in a directory RAM and a page-entry RAM.
//
// The request channel (req_valid, req_ready, req) takes one item that names
// an operation: map, unmap, set flags, translate, get flags or check access.
// Every item gives exactly one item on the result channel (rsp_valid,
// rsp_ready, rsp).
// An item steps through the states S_IDLE, which accepts it and reads the
// directory, S_DIR, which reads the page entry, and S_ENT, which writes back
// and loads the result register. A new item is taken only after the last
// has left S_ENT, as the dependent directory and entry reads cannot overlap.
// After reset the block clears both RAMs, one entry per cycle, with req_ready
// low: all TABLE_SLOTS * 1024 page entries (16384 by default).
// The result register lets the next item be accepted while a result waits.
// When the receiver stalls, an item that has finished its reads waits in its
// last step without writing until the result register is free.
// ----------------------------------------------------------------------------
module two_level_page_table_engine_core #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  tlpt_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output tlpt_pkg::rsp_t rsp
);

    import tlpt_pkg::*;

    localparam int SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int ENT_AW    = SLOT_W + IDX_W;
    localparam int CNT_W     = $clog2(TABLE_SLOTS + 1);
    localparam int ENT_DEPTH = TABLE_SLOTS * TBL_ENTRIES;

    logic               dir_we;
    logic [IDX_W-1:0]   dir_waddr;
    logic [SLOT_W:0]    dir_wdata;
    logic               dir_re;
    logic [IDX_W-1:0]   dir_raddr;
    logic [SLOT_W:0]    dir_rdata;
    logic               ent_we;
    logic [ENT_AW-1:0]  ent_waddr;
    logic [ENT_W-1:0]   ent_wdata;
    logic               ent_re;
    logic [ENT_AW-1:0]  ent_raddr;
    logic [ENT_W-1:0]   ent_rdata;

    tlpt_mem #(
        .DEPTH (DIR_ENTRIES),
        .AW    (IDX_W),
        .DW    (SLOT_W + 1)
    ) u_dir_mem (
        .clk   (clk),
        .we    (dir_we),
        .waddr (dir_waddr),
        .wdata (dir_wdata),
        .re    (dir_re),
        .raddr (dir_raddr),
        .rdata (dir_rdata)
    );

    tlpt_mem #(
        .DEPTH (ENT_DEPTH),
        .AW    (ENT_AW),
        .DW    (ENT_W)
    ) u_ent_mem (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    tlpt_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .SLOT_W      (SLOT_W),
        .ENT_AW      (ENT_AW),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .dir_we    (dir_we),
        .dir_waddr (dir_waddr),
        .dir_wdata (dir_wdata),
        .dir_re    (dir_re),
        .dir_raddr (dir_raddr),
        .dir_rdata (dir_rdata),
        .ent_we    (ent_we),
        .ent_waddr (ent_waddr),
        .ent_wdata (ent_wdata),
        .ent_re    (ent_re),
        .ent_raddr (ent_raddr),
        .ent_rdata (ent_rdata)
    );

endmodule
